// ===== hw/rtl/panel_delay_setting_controller_core_assert.svh =====
// assertion macros for the panel delay setting controller checker
// clocked on aclk, reset by aresetn (active low), taken in by the checker file
`ifndef PANEL_DELAY_SETTING_CONTROLLER_CORE_ASSERT_SVH
`define PANEL_DELAY_SETTING_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PDSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define PDSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also watches the reset itself
`define PDSC_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pdsc_pkg.sv =====
// shared types, constants and lookup functions of the panel delay setting controller
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package pdsc_pkg;

    // debounce ring
    localparam int DEBOUNCE_DEPTH = 10;
    localparam int RING_IDX_W = (DEBOUNCE_DEPTH > 1) ? $clog2(DEBOUNCE_DEPTH) : 1;

    // field widths
    localparam int SW_W      = 6;
    localparam int BTN_W     = 4;
    localparam int ENC_W     = 2;
    localparam int SET_W     = 10;
    localparam int COEFF_W   = 32;
    localparam int PROD_W    = SET_W + COEFF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int DELAY_W   = 24;
    localparam int Q_SHIFT   = 10;
    localparam int IDLE_W    = 16;
    localparam int DIV_W     = 8;
    localparam int MODE_W    = 8;
    localparam int SEG_W     = 7;
    localparam int WE_W      = 2;
    localparam int DIGIT_W   = 4;
    localparam int WRAP_W    = SET_W + 2;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 3 * SEG_W + WE_W + DELAY_W + 1;

    // three settings: frames, lines, samples; also three decimal digits
    localparam int NUM_SETTINGS = 3;
    localparam logic [1:0] LAST_STEP = 2'(NUM_SETTINGS - 1);

    // decimal split: x / 10 == (x * 205) >> 11 for x below 1029
    localparam int RECIP10       = 205;
    localparam int RECIP_SHIFT   = 11;
    localparam int RECIP_W       = 8;
    localparam int QPROD_W       = SET_W + RECIP_W;
    localparam int QUOT_W        = QPROD_W - RECIP_SHIFT;

    // fixed offset subtracted from the Q10 sum
    localparam logic [ACC_W-1:0] DELAY_OFFSET = ACC_W'(5 << Q_SHIFT);
    localparam logic [COEFF_W-1:0] Q10_ONE    = COEFF_W'(1 << Q_SHIFT);

    // modes
    localparam logic [MODE_W-1:0] MODE_FRAMES  = 8'd0;
    localparam logic [MODE_W-1:0] MODE_LINES   = 8'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLES = 8'd2;
    localparam logic [MODE_W-1:0] MODE_SELECT  = 8'd4;
    localparam logic [MODE_W-1:0] MODE_INIT    = 8'd254;
    localparam logic [MODE_W-1:0] MODE_NONE    = 8'd255;

    // single-button patterns (after inversion)
    localparam logic [BTN_W-1:0] BTN_CONFIRM = 4'b1000;
    localparam logic [BTN_W-1:0] BTN_FRAMES  = 4'b0100;
    localparam logic [BTN_W-1:0] BTN_LINES   = 4'b0010;
    localparam logic [BTN_W-1:0] BTN_SAMPLES = 4'b0001;

    localparam logic [WE_W-1:0] WE_OFF = 2'b00;
    localparam logic [WE_W-1:0] WE_ON  = 2'b11;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_MAX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COEFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COEFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV   = 3'd6;

    // configuration reset values
    localparam logic [SET_W-1:0]   RST_FRAMES_MAX   = 10'd42;
    localparam logic [SET_W-1:0]   RST_LINES_MAX    = 10'd625;
    localparam logic [SET_W-1:0]   RST_SAMPLES_MAX  = 10'd615;
    localparam logic [COEFF_W-1:0] RST_FRAME_COEFF  = 32'd393841254;
    localparam logic [COEFF_W-1:0] RST_LINE_COEFF   = 32'd630130;
    localparam logic [IDLE_W-1:0]  RST_IDLE_TIMEOUT = 16'd8000;
    localparam logic [DIV_W-1:0]   RST_SAMPLE_DIV   = 8'd4;

    // segment patterns, gcedfab
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
    localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;

    function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h21;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h6B;
            4'd4:    s = 7'h65;
            4'd5:    s = 7'h6E;
            4'd6:    s = 7'h7E;
            4'd7:    s = 7'h23;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [SEG_W-1:0] seg_of_mode(input logic [MODE_W-1:0] m);
        logic [SEG_W-1:0] s;
        case (m)
            MODE_FRAMES:  s = 7'b1010110;
            MODE_LINES:   s = 7'b0011100;
            MODE_SAMPLES: s = 7'b1110101;
            default:      s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       sample;
        logic       debounce;
        logic       button;
        logic       encoder;
        logic       mul;
        logic       accum;
        logic       scale;
        logic       sat;
        logic       timeout;
        logic       divide;
        logic       digit;
        logic [1:0] step;
        logic       emit;
    } pdsc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic enc_change;
        logic out_free;
    } pdsc_status_t;

endpackage

// ===== hw/rtl/pdsc_datapath.sv =====
// datapath: config registers, debounce ring, mode logic, shared multiplier,
// delay accumulator, decimal digit splitter and output word register; uses pdsc_pkg
`timescale 1ns / 1ps

module pdsc_datapath
    import pdsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pdsc_cmd_t              cmd,
    output pdsc_status_t           status,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEFF_W-1:0]     cfg_data,
    input  logic [SW_W-1:0]        pins,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    // configuration
    logic [SET_W-1:0]   frames_max_reg, lines_max_reg, samples_max_reg;
    logic [COEFF_W-1:0] frame_coeff_reg, line_coeff_reg;
    logic [IDLE_W-1:0]  idle_timeout_reg;
    logic [DIV_W-1:0]   sample_div_reg;

    // tick state
    logic [SW_W-1:0]       pins_reg;
    logic [SW_W-1:0]       ring_reg [DEBOUNCE_DEPTH];
    logic [RING_IDX_W-1:0] ring_pos_reg, ring_pos_next;
    logic [SW_W-1:0]       deb_reg, deb_next;
    logic [DIV_W-1:0]      phase_reg, phase_next;
    logic [MODE_W-1:0]     cur_mode_reg, pend_mode_reg;
    logic [BTN_W-1:0]      prev_btn_reg;
    logic [ENC_W-1:0]      prev_enc_reg;
    logic [WE_W-1:0]       we_reg;
    logic [SET_W-1:0]      setting_reg [NUM_SETTINGS];
    logic [DELAY_W-1:0]    delay_reg;
    logic [IDLE_W-1:0]     idle_reg;
    logic                  btn_event_reg;
    logic                  send_reg;

    // arithmetic
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ACC_W-1:0]    acc_reg;
    logic [SET_W-1:0]    dval_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [DIGIT_W-1:0]  digit_reg [NUM_SETTINGS];

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [BTN_W-1:0]  buttons;
    logic [ENC_W-1:0]  enc;
    logic [1:0]        cur_sel;
    logic [SET_W-1:0]  cur_setting;
    logic [SET_W-1:0]  cur_limit;
    logic [SET_W-1:0]  wrapped;
    logic [SET_W-1:0]  mul_a;
    logic [COEFF_W-1:0] mul_b;
    logic [SET_W-1:0]  dig_src;
    logic [QPROD_W-1:0] qprod;
    logic [SET_W-1:0]  rem;
    logic [SEG_W-1:0]  seg_u, seg_t, seg_h;
    logic [DIV_W:0]    phase_inc;
    logic [DIV_W-1:0]  div_eff;

    assign buttons = ~deb_reg[SW_W-1:ENC_W];
    assign enc     = deb_reg[ENC_W-1:0];

    // current mode as a setting index, clamped into the array
    always_comb begin
        case (cur_mode_reg)
            MODE_FRAMES: cur_sel = 2'd0;
            MODE_LINES:  cur_sel = 2'd1;
            default:     cur_sel = 2'd2;
        endcase
    end

    assign cur_setting = setting_reg[cur_sel];

    always_comb begin
        case (cur_sel)
            2'd0:    cur_limit = frames_max_reg;
            2'd1:    cur_limit = lines_max_reg;
            default: cur_limit = samples_max_reg;
        endcase
    end

    assign status.enc_change = (cur_mode_reg <= MODE_SELECT) && (enc != prev_enc_reg);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    // encoder step with a single modular correction
    always_comb begin
        logic signed [WRAP_W-1:0] v;
        logic signed [WRAP_W-1:0] step;
        logic signed [WRAP_W-1:0] lim;
        v    = signed'({2'b00, cur_setting});
        lim  = signed'({2'b00, cur_limit});
        step = (deb_reg[4:2] != 3'b111) ? WRAP_W'(10) : WRAP_W'(1);
        if (enc[0] && !prev_enc_reg[0]) begin
            if (enc[1]) begin
                v = v + step;
            end else begin
                v = v - step;
            end
        end
        if (v < 0) begin
            v = v + lim + WRAP_W'(1);
        end
        if (v > lim) begin
            v = v - lim - WRAP_W'(1);
        end
        wrapped = v[SET_W-1:0];
    end

    // shared multiplier operands
    always_comb begin
        case (cmd.step)
            2'd0: begin
                mul_a = setting_reg[0];
                mul_b = frame_coeff_reg;
            end
            2'd1: begin
                mul_a = setting_reg[1];
                mul_b = line_coeff_reg;
            end
            default: begin
                mul_a = setting_reg[2];
                mul_b = Q10_ONE;
            end
        endcase
    end

    assign prod_next = {{COEFF_W{1'b0}}, mul_a} * {{SET_W{1'b0}}, mul_b};

    // decimal digit split, one digit per divide and digit pair
    assign dig_src = (cmd.step == 2'd0) ? cur_setting : dval_reg;
    assign qprod   = {{RECIP_W{1'b0}}, dig_src} * QPROD_W'(RECIP10);
    assign rem     = dval_reg - {quot_reg, 3'b000} - {2'b00, quot_reg, 1'b0};

    // sample phase
    assign div_eff   = (sample_div_reg == '0) ? DIV_W'(1) : sample_div_reg;
    assign phase_inc = {1'b0, phase_reg} + (DIV_W + 1)'(1);
    assign phase_next = (phase_inc >= {1'b0, div_eff}) ? '0 : phase_inc[DIV_W-1:0];

    assign ring_pos_next = (ring_pos_reg == RING_IDX_W'(DEBOUNCE_DEPTH - 1)) ? '0
                                                                            : ring_pos_reg + 1'b1;

    always_comb begin
        deb_next = '1;
        for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
            deb_next = deb_next & ring_reg[i];
        end
    end

    // display selection
    always_comb begin
        seg_u = SEG_BLANK;
        seg_t = SEG_BLANK;
        seg_h = SEG_BLANK;
        if (cur_mode_reg < MODE_SELECT && cur_mode_reg != 8'd3) begin
            seg_u = seg_of_digit(digit_reg[0]);
            seg_t = seg_of_digit(digit_reg[1]);
            seg_h = seg_of_digit(digit_reg[2]);
        end else if (cur_mode_reg == MODE_NONE) begin
            seg_u = SEG_DASH;
            seg_t = SEG_DASH;
            seg_h = SEG_DASH;
        end else if (cur_mode_reg == MODE_INIT) begin
            seg_t = seg_of_digit(4'd0);
            seg_h = seg_of_digit(4'd1);
        end else if (cur_mode_reg == MODE_SELECT) begin
            seg_t = seg_of_mode(pend_mode_reg);
        end else begin
            seg_t = SEG_DASH;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_max_reg   <= RST_FRAMES_MAX;
            lines_max_reg    <= RST_LINES_MAX;
            samples_max_reg  <= RST_SAMPLES_MAX;
            frame_coeff_reg  <= RST_FRAME_COEFF;
            line_coeff_reg   <= RST_LINE_COEFF;
            idle_timeout_reg <= RST_IDLE_TIMEOUT;
            sample_div_reg   <= RST_SAMPLE_DIV;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAMES_MAX:   frames_max_reg   <= cfg_data[SET_W-1:0];
                CFG_LINES_MAX:    lines_max_reg    <= cfg_data[SET_W-1:0];
                CFG_SAMPLES_MAX:  samples_max_reg  <= cfg_data[SET_W-1:0];
                CFG_FRAME_COEFF:  frame_coeff_reg  <= cfg_data;
                CFG_LINE_COEFF:   line_coeff_reg   <= cfg_data;
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data[IDLE_W-1:0];
                CFG_SAMPLE_DIV:   sample_div_reg   <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SETTINGS; i++) begin
                setting_reg[i] <= '0;
            end
            ring_pos_reg  <= '0;
            deb_reg       <= '0;
            phase_reg     <= '0;
            cur_mode_reg  <= MODE_INIT;
            pend_mode_reg <= MODE_NONE;
            prev_btn_reg  <= '0;
            prev_enc_reg  <= '0;
            we_reg        <= WE_OFF;
            delay_reg     <= '0;
            idle_reg      <= '0;
            btn_event_reg <= 1'b0;
            send_reg      <= 1'b0;
        end else begin
            if (cmd.sample) begin
                if (phase_reg == '0) begin
                    ring_reg[ring_pos_reg] <= pins_reg;
                    ring_pos_reg           <= ring_pos_next;
                end
                phase_reg <= phase_next;
            end

            if (cmd.debounce) begin
                deb_reg <= deb_next;
            end

            if (cmd.button) begin
                btn_event_reg <= 1'b0;
                if (buttons != prev_btn_reg) begin
                    prev_btn_reg <= buttons;
                    if (buttons != '0) begin
                        btn_event_reg <= 1'b1;
                        cur_mode_reg  <= MODE_SELECT;
                        case (buttons)
                            BTN_CONFIRM: begin
                                cur_mode_reg <= pend_mode_reg;
                                we_reg       <= (we_reg != WE_OFF) ? WE_OFF : WE_ON;
                            end
                            BTN_FRAMES:  pend_mode_reg <= MODE_FRAMES;
                            BTN_LINES:   pend_mode_reg <= MODE_LINES;
                            BTN_SAMPLES: pend_mode_reg <= MODE_SAMPLES;
                            default:     pend_mode_reg <= MODE_NONE;
                        endcase
                    end
                end
            end

            if (cmd.encoder) begin
                send_reg <= status.enc_change;
                if (status.enc_change) begin
                    prev_enc_reg <= enc;
                    if (cur_mode_reg < 8'd3) begin
                        setting_reg[cur_sel] <= wrapped;
                    end
                end
            end

            if (cmd.sat) begin
                delay_reg <= (acc_reg[ACC_W-1:DELAY_W+Q_SHIFT] != '0)
                           ? '1 : acc_reg[DELAY_W+Q_SHIFT-1:Q_SHIFT];
            end

            if (cmd.timeout) begin
                if (btn_event_reg) begin
                    idle_reg <= '0;
                end else if (idle_reg >= idle_timeout_reg) begin
                    idle_reg     <= '0;
                    cur_mode_reg <= pend_mode_reg;
                    send_reg     <= 1'b1;
                end else begin
                    idle_reg <= idle_reg + 1'b1;
                end
            end
        end
    end

    // arithmetic payload, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pins_reg <= pins;
        end
        if (cmd.encoder) begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.mul || cmd.accum) begin
            acc_reg <= acc_reg + {2'b00, prod_reg};
        end
        if (cmd.scale && acc_reg > DELAY_OFFSET) begin
            acc_reg <= acc_reg - DELAY_OFFSET;
        end
        if (cmd.divide) begin
            dval_reg <= dig_src;
            quot_reg <= qprod[QPROD_W-1:RECIP_SHIFT];
        end
        if (cmd.digit) begin
            digit_reg[cmd.step] <= rem[DIGIT_W-1:0];
            dval_reg            <= {{(SET_W-QUOT_W){1'b0}}, quot_reg};
        end
        if (cmd.emit) begin
            m_tdata_reg <= {send_reg, delay_reg, we_reg, seg_h, seg_t, seg_u};
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/pdsc_ctrl.sv =====
// controller: one-hot sequencer that walks each tick through the datapath steps
// uses pdsc_pkg for the command and status structs
`timescale 1ns / 1ps

module pdsc_ctrl
    import pdsc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  pdsc_status_t status,
    output pdsc_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_SAMPLE   = 13'b0000000000010,
        S_DEBOUNCE = 13'b0000000000100,
        S_BUTTON   = 13'b0000000001000,
        S_ENCODER  = 13'b0000000010000,
        S_MUL      = 13'b0000000100000,
        S_ACC      = 13'b0000001000000,
        S_SCALE    = 13'b0000010000000,
        S_SAT      = 13'b0000100000000,
        S_TIMEOUT  = 13'b0001000000000,
        S_DIVIDE   = 13'b0010000000000,
        S_DIGIT    = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_SAMPLE;
                end
            end
            S_SAMPLE: begin
                cmd.sample = 1'b1;
                state_next = S_DEBOUNCE;
            end
            S_DEBOUNCE: begin
                cmd.debounce = 1'b1;
                state_next   = S_BUTTON;
            end
            S_BUTTON: begin
                cmd.button = 1'b1;
                state_next = S_ENCODER;
            end
            S_ENCODER: begin
                cmd.encoder = 1'b1;
                step_next   = '0;
                state_next  = status.enc_change ? S_MUL : S_TIMEOUT;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    state_next = S_ACC;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ACC: begin
                cmd.accum  = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_SAT;
            end
            S_SAT: begin
                cmd.sat    = 1'b1;
                state_next = S_TIMEOUT;
            end
            S_TIMEOUT: begin
                cmd.timeout = 1'b1;
                step_next   = '0;
                state_next  = S_DIVIDE;
            end
            S_DIVIDE: begin
                cmd.divide = 1'b1;
                state_next = S_DIGIT;
            end
            S_DIGIT: begin
                cmd.digit = 1'b1;
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    state_next = S_EMIT;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_EMIT: begin
                // wait here while the previous word is still held
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/panel_delay_setting_controller_core.sv =====
// channel   | dir | handshake          | word
// s_        | in  | s_tvalid/s_tready  | one timer tick: switch pin levels
// m_        | out | m_tvalid/m_tready  | display segments, write enable, delay, send flag
// cfg_      | in  | cfg_valid/cfg_ready| register index and write data
//
// a tick runs from the accept through sample, debounce, button, encoder, timeout, the
// decimal digit split and emit; when the encoder moved, the delay is recomputed through the
// shared 10x32 multiplier (three products, then offset and saturation) before timeout,
// and the decimal digit split runs on every tick.
// the result sits in an output register, so the next tick is accepted while it waits;
// a stalled m_ side holds the sequencer only at its final step.
// aresetn is synchronous and active low; configuration is always ready.
//
// top level of the panel delay setting controller; uses pdsc_pkg, pdsc_ctrl, pdsc_datapath
`timescale 1ns / 1ps

module panel_delay_setting_controller_core
    import pdsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,    // [5:0] raw_switches, [7:6] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // [6:0] segments_units, [13:7] segments_tens,
                                               // [20:14] segments_hundreds,
                                               // [22:21] write_enable_out,
                                               // [46:23] delay_samples, [47] delay_send
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEFF_W-1:0]     cfg_data
);

    pdsc_cmd_t    cmd;
    pdsc_status_t status;

    assign cfg_ready = 1'b1;

    pdsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdsc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pins      (s_tdata[SW_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hw/rtl/pdsc_checker.sv =====
// port-level checker for the panel delay setting controller, bound to the top level
// uses pdsc_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "panel_delay_setting_controller_core_assert.svh"

module pdsc_checker
    import pdsc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a held word must not change under back-pressure
    `PDSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // one tick at a time: the input side closes right after an accept
    `PDSC_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready, "second word accepted during a tick")

    // write enable lines are either both off or both on
    `PDSC_ASSERT_NOW(a_we_code, m_tvalid, m_tdata[22:21] == WE_OFF || m_tdata[22:21] == WE_ON, "write enable field out of code")

    // reset leaves no result pending
    `PDSC_ASSERT_RST(a_rst_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind panel_delay_setting_controller_core pdsc_checker u_pdsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
